// ===== hdl/md5sh_pkg.sv =====
package md5sh_pkg;

  typedef logic [31:0] word_t;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_EMIT
  } state_t;

  // Block positions, pad marker and last round, digest word and length byte
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [1:0] LAST_IDX = 2'd3;
  localparam logic [2:0] LAST_LEN = 3'd7;

  // Chaining word initial values A, B, C, D
  localparam word_t IV_TAB [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Per-round additive constants
  localparam word_t K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {phase, round[1:0]}
  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    return i;
      2'd1:    return 4'(i * 4'd5 + 4'd1);
      2'd2:    return 4'(i * 4'd3 + 4'd5);
      default: return 4'(i * 4'd7);
    endcase
  endfunction

  // Boolean mixing function of a phase
  function automatic word_t round_f(input logic [1:0] phase, input word_t b,
                                    input word_t c, input word_t d);
    case (phase)
      2'd0:    return (b & c) | (~b & d);
      2'd1:    return (b & d) | (c & ~d);
      2'd2:    return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

// ===== hdl/md5sh_compress.sv =====
module md5sh_compress (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  md5sh_pkg::word_t  chain_i [4],
  input  md5sh_pkg::word_t  blk_word_i,
  output logic [3:0]        blk_idx_o,
  output logic              done_o,
  output md5sh_pkg::word_t  chain_o [4]
);
  import md5sh_pkg::*;

  logic       busy_r, busy_nxt;
  logic       fin_r, fin_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  word_t      a_r, b_r, c_r, d_r, t_r;
  word_t      a_nxt, b_nxt, c_nxt, d_nxt, t_nxt;
  logic [5:0] rnd_inc;
  word_t      f_val, sum_val, rot_val;

  // Round datapath: t_r already holds a + K + M for this round
  always_comb begin
    rnd_inc   = rnd_r + 6'd1;
    blk_idx_o = busy_r ? msg_index(rnd_inc) : 4'd0;
    f_val     = round_f(rnd_r[5:4], b_r, c_r, d_r);
    sum_val   = t_r + f_val;
    rot_val   = rotl(sum_val, ROT_TAB[{rnd_r[5:4], rnd_r[1:0]}]);
  end

  // Next values of the round registers
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    rnd_nxt  = rnd_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    t_nxt    = t_r;
    if (start) begin
      busy_nxt = 1'b1;
      rnd_nxt  = '0;
      a_nxt    = chain_i[0];
      b_nxt    = chain_i[1];
      c_nxt    = chain_i[2];
      d_nxt    = chain_i[3];
      t_nxt    = chain_i[0] + K_TAB[0] + blk_word_i;
    end else if (busy_r) begin
      rnd_nxt = rnd_inc;
      a_nxt   = d_r;
      b_nxt   = b_r + rot_val;
      c_nxt   = b_r;
      d_nxt   = c_r;
      // next round's a is today's d
      t_nxt   = d_r + K_TAB[rnd_inc] + blk_word_i;
      if (rnd_r == LAST_RND) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    t_r <= t_nxt;
  end

  // Feed-forward add into the chaining words
  assign done_o     = fin_r;
  assign chain_o[0] = chain_i[0] + a_r;
  assign chain_o[1] = chain_i[1] + b_r;
  assign chain_o[2] = chain_i[2] + c_r;
  assign chain_o[3] = chain_i[3] + d_r;

endmodule

// ===== hdl/md5_stream_hasher_core.sv =====
// Channel | Dir | tdata                  | tuser           | tlast
// in_     | in  | [7:0] data_byte        | byte_valid      | last_byte
// out_    | out | [31:0] digest_word     | [1:0] word_index| last_word
//
// A message byte is written to the block buffer as it is taken; a byte that
// fills a block starts 64 rounds of the shared round unit, then the
// feed-forward add. On the end marker, padding goes one byte per cycle to
// the block end, then that block is compressed; a second block follows when
// the length no longer fits. The four digest words then go one per transfer.
// Synchronous active-low reset loads the initial chaining words and clears
// the bit count. in_tready is low while padding, compressing or emitting.
module md5_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);
  import md5sh_pkg::*;

  state_t      state_r, state_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        mark_r, mark_nxt;
  logic        lenph_r, lenph_nxt;
  logic [2:0]  lenk_r, lenk_nxt;
  logic        final_r, final_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  idx_r, idx_nxt;
  word_t       chain_r [4];
  word_t       chain_nxt [4];
  word_t       blk_r [16];

  logic        in_xfer, out_xfer;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic        cmp_start, cmp_done;
  logic [3:0]  cmp_idx;
  word_t       cmp_chain [4];

  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign cmp_start = wr_en && (wr_pos == LAST_POS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser && (cnt_r[8:3] == LAST_POS)) state_nxt = ST_COMP;
          else if (in_tlast)                        state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos_r == LAST_POS) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (cmp_done) begin
          if (!fin_r)       state_nxt = ST_IDLE;
          else if (final_r) state_nxt = ST_EMIT;
          else              state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_xfer && (idx_r == LAST_IDX)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, block writes and counters
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    wr_en      = 1'b0;
    wr_pos     = pos_r;
    wr_byte    = '0;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    mark_nxt   = mark_r;
    lenph_nxt  = lenph_r;
    lenk_nxt   = lenk_r;
    final_nxt  = final_r;
    fin_nxt    = fin_r;
    idx_nxt    = idx_r;
    chain_nxt  = chain_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // ready is high here, so a valid input is a transfer
        if (in_tvalid) begin
          if (in_tuser) begin
            wr_en   = 1'b1;
            wr_pos  = cnt_r[8:3];
            wr_byte = in_tdata;
            cnt_nxt = cnt_r + 64'd8;
          end
          fin_nxt = in_tlast;
          if (in_tlast) begin
            pos_nxt   = cnt_nxt[8:3];
            mark_nxt  = 1'b1;
            lenph_nxt = 1'b0;
            lenk_nxt  = '0;
            final_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        wr_en  = 1'b1;
        wr_pos = pos_r;
        if (mark_r)       wr_byte = PAD_MARK;
        else if (lenph_r) wr_byte = cnt_r[{lenk_r, 3'b000} +: 8];
        pos_nxt  = pos_r + 6'd1;
        mark_nxt = 1'b0;
        if (lenph_r) begin
          lenk_nxt = lenk_r + 3'd1;
          if (lenk_r == LAST_LEN) final_nxt = 1'b1;
        end else if (pos_nxt == LEN_POS) begin
          lenph_nxt = 1'b1;
        end
      end
      ST_COMP: begin
        if (cmp_done) chain_nxt = cmp_chain;
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        // valid is high here, so ready completes a transfer
        if (out_tready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == LAST_IDX) begin
            chain_nxt = IV_TAB;
            cnt_nxt   = '0;
            fin_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      mark_r  <= 1'b0;
      lenph_r <= 1'b0;
      lenk_r  <= '0;
      final_r <= 1'b0;
      fin_r   <= 1'b0;
      idx_r   <= '0;
      chain_r <= IV_TAB;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      mark_r  <= mark_nxt;
      lenph_r <= lenph_nxt;
      lenk_r  <= lenk_nxt;
      final_r <= final_nxt;
      fin_r   <= fin_nxt;
      idx_r   <= idx_nxt;
      chain_r <= chain_nxt;
    end
  end

  // Block buffer, bytes packed little-endian into words
  always_ff @(posedge clk) begin
    if (wr_en) blk_r[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
  end

  md5sh_compress u_compress (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmp_start),
    .chain_i    (chain_r),
    .blk_word_i (blk_r[cmp_idx]),
    .blk_idx_o  (cmp_idx),
    .done_o     (cmp_done),
    .chain_o    (cmp_chain)
  );

  // Digest words straight from the chaining registers
  assign out_tdata = chain_r[idx_r];
  assign out_tuser = idx_r;
  assign out_tlast = (idx_r == LAST_IDX);

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while digest pending");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_done |-> (state_r == ST_COMP))
    else $error("compression finished outside compress state");

  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && (cnt_r == '0)))
    else $error("no reinit after final digest word");

endmodule
